// ===== sv/xml_entity_unescape_stream_macros.svh =====
// Assertion macros for the entity decoder. Each macro expects clk and rst_n
// to be visible where it is used.
`ifndef XML_ENTITY_UNESCAPE_STREAM_MACROS_SVH
`define XML_ENTITY_UNESCAPE_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define XEU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define XEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XEU_ASSERT_SAME(label, ante, cons, msg)
`define XEU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/xeu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xeu_pkg;

  // Longest entity name that is held between the ampersand and the semicolon.
  localparam logic [2:0] ENT_MAX = 3'd4;

  typedef logic [2:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_ENTITY  = 2'd1,
    MODE_SWALLOW = 2'd2
  } mode_t;

  // One input byte with its end-of-string flag.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       eos;
    logic       err;
    logic       has;
    logic [7:0] byte_val;
  } res_t;

  // Character codes.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG2  = 8'h32;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

`default_nettype wire

// ===== sv/xeu_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xeu_in_stage
  import xeu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  down_ready,
  output logic       item_valid,
  output item_t      item,
  output logic       adv
);

  logic  v_r;
  logic  v_nxt;
  item_t item_r;

  // The held byte moves on whenever the result side can take whatever it causes.
  assign adv        = v_r && down_ready;
  assign in_ready   = !v_r || down_ready;
  assign item_valid = v_r;
  assign item       = item_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xeu_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "xml_entity_unescape_stream_macros.svh"

module xeu_decoder
  import xeu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire item_t item,
  output logic       res_emit,
  output res_t       res
);

  mode_t      mode_r;
  mode_t      mode_nxt;
  cnt_t       cnt_r;
  cnt_t       cnt_nxt;
  logic [7:0] ent_r [4];
  logic       store;
  logic [8:0] hit;

  // Returns the decoded character with a hit flag on top, or zero.
  function automatic logic [8:0] match_ent(input logic [7:0] e0, input logic [7:0] e1,
                                           input logic [7:0] e2, input logic [7:0] e3,
                                           input cnt_t n);
    logic [8:0] r;
    r = '0;
    if (n == 3'd2 && e0 == CH_L && e1 == CH_T) begin
      r = {1'b1, CH_LT};
    end else if (n == 3'd2 && e0 == CH_G && e1 == CH_T) begin
      r = {1'b1, CH_GT};
    end else if (n == 3'd3 && e0 == CH_A && e1 == CH_M && e2 == CH_P) begin
      r = {1'b1, CH_AMP};
    end else if (n == 3'd4 && e0 == CH_A && e1 == CH_P && e2 == CH_O && e3 == CH_S) begin
      r = {1'b1, CH_APOS};
    end else if (n == 3'd4 && e0 == CH_Q && e1 == CH_U && e2 == CH_O && e3 == CH_T) begin
      r = {1'b1, CH_QUOT};
    end else if (n == 3'd4 && e0 == CH_HASH && e1 == CH_X && e2 == CH_DIG2
                 && e3 == CH_DIG0) begin
      r = {1'b1, CH_SPACE};
    end
    return r;
  endfunction

  assign hit = match_ent(ent_r[0], ent_r[1], ent_r[2], ent_r[3], cnt_r);

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    store    = 1'b0;
    res_emit = 1'b0;
    res      = '{eos: item.last, err: 1'b0, has: 1'b0, byte_val: 8'h00};
    case (mode_r)
      MODE_SWALLOW: begin
        if (item.last) begin
          res_emit = 1'b1;
          res.err  = 1'b1;
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_ENTITY: begin
        if (item.byte_val == CH_SEMI && hit[8]) begin
          res_emit     = 1'b1;
          res.has      = 1'b1;
          res.byte_val = hit[7:0];
          cnt_nxt      = '0;
          mode_nxt     = MODE_PLAIN;
        end else if (item.byte_val == CH_SEMI || item.byte_val == CH_NUL
                     || cnt_r >= ENT_MAX || item.last) begin
          // Unknown name, over-long name, zero byte or string end: error.
          res_emit = 1'b1;
          res.err  = 1'b1;
          cnt_nxt  = '0;
          mode_nxt = item.last ? MODE_PLAIN : MODE_SWALLOW;
        end else begin
          store   = 1'b1;
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      default: begin
        if (item.byte_val == CH_AMP) begin
          cnt_nxt = '0;
          if (item.last) begin
            res_emit = 1'b1;
            res.err  = 1'b1;
            mode_nxt = MODE_PLAIN;
          end else begin
            mode_nxt = MODE_ENTITY;
          end
        end else begin
          res_emit     = 1'b1;
          res.has      = 1'b1;
          res.byte_val = item.byte_val;
          mode_nxt     = MODE_PLAIN;
        end
      end
    endcase
    if (!adv) begin
      res_emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && store) begin
      ent_r[cnt_r[1:0]] <= item.byte_val;
    end
  end

  `XEU_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= ENT_MAX, "entity count beyond limit")
  `XEU_ASSERT_SAME(a_cnt_idle, mode_r != MODE_ENTITY, cnt_r == 3'd0,
                   "entity bytes held outside an entity")
  `XEU_ASSERT_SAME(a_res_kind, res_emit, !(res.has && res.err),
                   "result carries a character and an error")
  `XEU_ASSERT_NEXT(a_last_plain, adv && item.last, mode_r == MODE_PLAIN,
                   "not back in plain text after string end")

endmodule

`default_nettype wire

// ===== sv/xeu_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xeu_out_stage
  import xeu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic v_r;
  logic v_nxt;
  res_t res_r;

  assign can_load  = !v_r || out_ready;
  assign out_valid = v_r;
  assign res_out   = res_r;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = 1'b1;
    end else if (out_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xml_entity_unescape_stream.sv =====
// Streaming XML entity decoder. One byte of an escaped string enters per
// request on the in_ channel, with in_tlast on the string's final byte.
// Ordinary bytes come out unchanged; &lt; &gt; &amp; &apos; &quot; and &#x20;
// (case-sensitive) come out as the single character they stand for, on the
// request that carries the semicolon. Bytes inside an entity give no result.
// An unknown or malformed entity (no match, more than four name bytes, a zero
// byte, or the string ending inside an entity) gives one error result; the
// rest of that string is dropped and only an end marker with the error flag
// follows on the last byte. The consumer should discard a string that ends
// with decode_error set. Every input request with in_tlast high produces
// exactly one result with out_tlast high, after which the decoder is back in
// plain text. Throughput is one byte per clock while out_tready stays high:
// a byte is held in the input register, the decode step (six fixed name
// compares) runs between that register and the output register, and the
// output register can load a new result as out_tready takes the waiting one.
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_unescape_stream
  import xeu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [0] has_byte, [1] decode_error
  output logic            out_tlast   // end_of_string
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  adv;
  logic  can_load;
  logic  res_emit;
  res_t  res;
  res_t  res_out;

  assign in_item = '{byte_val: in_tdata, last: in_tlast};

  // Input register: holds one byte until the output side can take its result.
  xeu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .down_ready (can_load),
    .item_valid (item_valid),
    .item       (item),
    .adv        (adv)
  );

  // Decode step with the parse state and the held entity bytes. The state only
  // moves when the held byte advances, so a stall never repeats a step.
  xeu_decoder u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (item),
    .res_emit (res_emit),
    .res      (res)
  );

  // Output register. Bytes that give no result advance without loading it.
  xeu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_emit && item_valid),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_out)
  );

  assign out_tdata = res_out.byte_val;
  assign out_tuser = {res_out.err, res_out.has};
  assign out_tlast = res_out.eos;

endmodule

`default_nettype wire

// ===== tb/sv/entity_decode_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the entity decoder, predicts the result of every
// accepted input byte and compares each accepted result with the oldest
// prediction.
module entity_decode_checker
  import xeu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic [1:0] out_tuser,
  input  wire logic       out_tlast,
  output int              mismatch_count,
  output int              outstanding,
  output int              results_checked,
  output int              error_results
);

  localparam int REPORT_MAX = 20;

  mode_t      parse_mode;
  logic [7:0] held [0:3];
  cnt_t       held_cnt;
  res_t       expected_chars [$];
  int         reports;

  // Looks up the held name; returns 1 and the character on a match.
  function automatic bit match_held(output logic [7:0] ch);
    ch = CH_NUL;
    match_held = 1'b1;
    if (held_cnt == 3'd2 && held[0] == CH_L && held[1] == CH_T) begin
      ch = CH_LT;
    end else if (held_cnt == 3'd2 && held[0] == CH_G && held[1] == CH_T) begin
      ch = CH_GT;
    end else if (held_cnt == 3'd3 && held[0] == CH_A && held[1] == CH_M &&
                 held[2] == CH_P) begin
      ch = CH_AMP;
    end else if (held_cnt == ENT_MAX && held[0] == CH_A && held[1] == CH_P &&
                 held[2] == CH_O && held[3] == CH_S) begin
      ch = CH_APOS;
    end else if (held_cnt == ENT_MAX && held[0] == CH_Q && held[1] == CH_U &&
                 held[2] == CH_O && held[3] == CH_T) begin
      ch = CH_QUOT;
    end else if (held_cnt == ENT_MAX && held[0] == CH_HASH && held[1] == CH_X &&
                 held[2] == CH_DIG2 && held[3] == CH_DIG0) begin
      ch = CH_SPACE;
    end else begin
      match_held = 1'b0;
    end
  endfunction

  // Error result; the rest of the string is dropped unless this byte ends it.
  function automatic res_t entity_error(input logic last);
    res_t r;
    r = '0;
    r.err = 1'b1;
    r.eos = last;
    held_cnt = '0;
    if (last) begin
      parse_mode = MODE_PLAIN;
    end else begin
      parse_mode = MODE_SWALLOW;
    end
    return r;
  endfunction

  // One decode step for an accepted byte.
  task automatic decode_step(input logic [7:0] b, input logic last,
                             output bit produced, output res_t r);
    logic [7:0] ch;
    produced = 1'b1;
    r = '0;
    case (parse_mode)
      MODE_SWALLOW: begin
        if (!last) begin
          produced = 1'b0;
        end else begin
          parse_mode = MODE_PLAIN;
          r.err = 1'b1;
          r.eos = 1'b1;
        end
      end
      MODE_ENTITY: begin
        if (b == CH_SEMI) begin
          if (match_held(ch)) begin
            held_cnt = '0;
            parse_mode = MODE_PLAIN;
            r.byte_val = ch;
            r.has = 1'b1;
            r.eos = last;
          end else begin
            r = entity_error(last);
          end
        end else if (b == CH_NUL || held_cnt >= ENT_MAX || last) begin
          r = entity_error(last);
        end else begin
          held[held_cnt[1:0]] = b;
          held_cnt = held_cnt + 3'd1;
          produced = 1'b0;
        end
      end
      default: begin
        // Plain text; the unused mode value behaves the same way.
        if (b == CH_AMP) begin
          held_cnt = '0;
          if (last) begin
            r = entity_error(1'b1);
          end else begin
            parse_mode = MODE_ENTITY;
            produced = 1'b0;
          end
        end else begin
          parse_mode = MODE_PLAIN;
          r.byte_val = b;
          r.has = 1'b1;
          r.eos = last;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    res_t next_res;
    bit   produced;
    if (!rst_n) begin
      parse_mode = MODE_PLAIN;
      held_cnt = '0;
      for (int i = 0; i < 4; i++) held[i] = CH_NUL;
      expected_chars.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.byte_val = out_tdata;
        got.has = out_tuser[0];
        got.err = out_tuser[1];
        got.eos = out_tlast;
        if (expected_chars.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (reports < REPORT_MAX) begin
            $display("%0t: unexpected result byte=%02h has=%0b err=%0b eos=%0b",
                     $time, got.byte_val, got.has, got.err, got.eos);
          end
          reports++;
        end else begin
          want = expected_chars.pop_front();
          results_checked <= results_checked + 1;
          if (want.err) error_results <= error_results + 1;
          if (got.byte_val !== want.byte_val || got.has !== want.has ||
              got.err !== want.err || got.eos !== want.eos) begin
            mismatch_count <= mismatch_count + 1;
            if (reports < REPORT_MAX) begin
              $display("%0t: mismatch, expected byte=%02h has=%0b err=%0b eos=%0b, %s",
                       $time, want.byte_val, want.has, want.err, want.eos, "got");
              $display("%0t:   actual byte=%02h has=%0b err=%0b eos=%0b",
                       $time, got.byte_val, got.has, got.err, got.eos);
            end
            reports++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_step(in_tdata, in_tlast, produced, next_res);
        if (produced) expected_chars.insert(expected_chars.size(), next_res);
      end
      outstanding <= expected_chars.size();
    end
  end

endmodule

// ===== tb/sv/tb_xml_entity_unescape_stream.sv =====
`timescale 1ns / 1ps

// Testbench top for the streaming entity decoder. This module only makes
// stimulus and gives the verdict; prediction and comparison live in the
// checker instance that watches both streams.
module tb_xml_entity_unescape_stream;
  import xeu_pkg::*;

  localparam int         RANDOM_ITEMS = 550;
  localparam logic [7:0] LETTER_Z     = 8'h7A;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int error_results;

  // Stimulus bookkeeping. A calm string adds no idle gaps of its own on either side.
  bit         calm;
  bit         swallowing;
  int         counted_items;
  int         bytes_sent;
  int         strings_sent;
  int         ready_left;
  logic [7:0] text_q [$];

  xml_entity_unescape_stream u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  entity_decode_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .error_results  (error_results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the decoder hangs on either stream.
  initial begin
    #2_000_000;
    $display("tb_xml_entity_unescape_stream: FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // The result side alternates between ready stretches and stalls.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 65) begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(0, 8);
      end else begin
        out_tready <= 1'b0;
        ready_left <= pick_gap();
      end
    end
  end

  // Offers one byte, after a random idle gap, and holds it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Bytes are gathered into a string first, so that the last one can be
  // flagged. Bytes that the decoder will only swallow are not counted.
  task automatic put(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
    if (!swallowing) counted_items++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic send_string();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
    swallowing = 1'b0;
    strings_sent++;
  endtask

  function automatic string entity_name(input int k);
    case (k)
      0: return "lt";
      1: return "gt";
      2: return "amp";
      3: return "apos";
      4: return "quot";
      default: return "#x20";
    endcase
  endfunction

  task automatic put_letters(input int n);
    for (int i = 0; i < n; i++) put(8'($urandom_range(CH_A, LETTER_Z)));
  endtask

  // A broken entity of a random kind. Returns 1 when the string must end
  // right here, with the entity still open.
  task automatic put_broken(output bit truncated);
    string      s;
    int         k;
    logic [7:0] b;
    truncated = 1'b0;
    put(CH_AMP);
    case ($urandom_range(0, 5))
      0: begin
        // Unknown name of one to four letters.
        put_letters($urandom_range(1, 4));
        put(CH_SEMI);
      end
      1: begin
        // Name longer than four bytes.
        for (int i = 0; i < 5; i++) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_SEMI) b = CH_X;
          put(b);
        end
      end
      2: begin
        // Zero byte inside the name.
        put_letters($urandom_range(0, 3));
        put(CH_NUL);
      end
      3: begin
        // Known name with bit 5 of one character flipped (the wrong case for a letter).
        s = entity_name($urandom_range(0, 5));
        k = $urandom_range(0, s.len() - 1);
        s[k] = s[k] ^ 8'h20;
        put_text(s);
        put(CH_SEMI);
      end
      4: begin
        put(CH_SEMI);
      end
      default: begin
        put_letters($urandom_range(0, 3));
        truncated = 1'b1;
      end
    endcase
    swallowing = 1'b1;
  endtask

  // Mostly well-formed text with random content, with some broken entities.
  task automatic build_random_string();
    int         segs;
    int         r;
    logic [7:0] b;
    bit         truncated;
    segs = $urandom_range(1, 10);
    for (int s = 0; s < segs; s++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_AMP) b = CH_SEMI;
        put(b);
      end else if (r < 88) begin
        put(CH_AMP);
        put_text(entity_name($urandom_range(0, 5)));
        put(CH_SEMI);
      end else begin
        put_broken(truncated);
        if (!truncated) begin
          for (int i = $urandom_range(0, 3); i > 0; i--) put(8'($urandom_range(0, 255)));
        end
        break;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: byte extremes in plain text, a match, an empty
    // entity, a zero byte in a name followed by a swallowed tail, a name one
    // byte too long, a string ending inside an entity and a lone ampersand.
    put(CH_NUL);
    put(8'hFF);
    send_string();
    put_text("&amp;");
    send_string();
    put_text("&;");
    send_string();
    put(CH_AMP);
    put(CH_NUL);
    put(CH_X);
    send_string();
    put_text("&quotx;");
    send_string();
    put_text("&l");
    send_string();
    put(CH_AMP);
    send_string();

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      build_random_string();
      send_string();
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d strings, %0d bytes; checked %0d results, %0d of them decode errors.",
             strings_sent, bytes_sent, results_checked, error_results);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_xml_entity_unescape_stream: PASS");
    end else begin
      $display("tb_xml_entity_unescape_stream: FAIL");
    end
    $finish;
  end

endmodule

// ===== xml_entity_unescape_stream.f =====
+incdir+sv
sv/xeu_pkg.sv
sv/xeu_in_stage.sv
sv/xeu_decoder.sv
sv/xeu_out_stage.sv
sv/xml_entity_unescape_stream.sv
tb/sv/entity_decode_checker.sv
tb/sv/tb_xml_entity_unescape_stream.sv
